// ----- src/coalescing_type_queue_macros.svh -----
// Assertion macros shared by the coalescing type queue RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef COALESCING_TYPE_QUEUE_MACROS_SVH
`define COALESCING_TYPE_QUEUE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication under reset.
`define CTQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("coalescing queue assertion failed");
// Next-cycle implication under reset.
`define CTQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("coalescing queue assertion failed");
`else
`define CTQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CTQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/ctq_pkg.sv -----
// Types and constants for the coalescing type queue.
// No dependencies; used by the interfaces, the cell and the top level.
package ctq_pkg;

    localparam int TYPE_W           = 4;
    localparam int PAYLOAD_W        = 32;
    localparam int OCC_W            = 5;
    localparam int NUM_TYPES_DEF    = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    typedef enum logic {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } ctq_op_t;

    typedef enum logic [1:0] {
        ST_ENQ     = 2'd0,
        ST_REPLACE = 2'd1,
        ST_DEQ     = 2'd2,
        ST_EMPTY   = 2'd3
    } ctq_status_t;

    typedef struct packed {
        ctq_op_t               op;
        logic [TYPE_W-1:0]     msg_type;
        logic [PAYLOAD_W-1:0]  payload;
    } ctq_req_t;

    typedef struct packed {
        ctq_status_t           status;
        logic [TYPE_W-1:0]     out_type;
        logic [PAYLOAD_W-1:0]  out_payload;
        logic [OCC_W-1:0]      occupancy;
    } ctq_rsp_t;

    // Per-cell command from the queue control
    typedef struct packed {
        logic en;        // transaction accepted this cycle
        logic enq;       // operation is an enqueue
        logic occupied;  // cell holds a queued entry
        logic load_new;  // cell is the new tail
    } ctq_cell_cmd_t;

endpackage

// ----- src/ctq_intf.sv -----
// Valid/ready channel interfaces for the coalescing type queue.
// Depends on ctq_pkg for the payload structs.
interface ctq_req_if;
    import ctq_pkg::*;

    logic     valid;
    logic     ready;
    ctq_req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ctq_rsp_if;
    import ctq_pkg::*;

    logic     valid;
    logic     ready;
    ctq_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/coalescing_type_queue.sv -----
// Coalescing type queue: an accepted transaction's result is in the output register
// in the next cycle; one transaction per cycle is sustained while the output is not
// stalled, with the match and shift across the cell chain done combinationally.
// The next transaction is accepted while a result waits, if the result is taken.
// Reset clears the fill count and the output valid; slot contents are not
// cleared and are never read before they are written.
module coalescing_type_queue #(
    parameter int NUM_TYPES    = ctq_pkg::NUM_TYPES_DEF,
    parameter int PAYLOAD_BITS = ctq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    ctq_req_if.sink     req,
    ctq_rsp_if.source   rsp
);
    import ctq_pkg::*;

    `include "coalescing_type_queue_macros.svh"

    localparam int CNT_W = $clog2(NUM_TYPES + 1);

    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic [CNT_W-1:0]        cnt_after;
    logic                    rsp_valid_reg;
    ctq_rsp_t                rsp_reg;
    ctq_rsp_t                rsp_next;

    logic                    accept;
    logic                    is_enq;
    logic                    empty;
    logic                    full;
    logic                    any_hit;
    logic                    drop_head;
    logic                    removed;
    logic [63:0]             in_pay64;
    logic [63:0]             head_pay64;
    logic [PAYLOAD_BITS-1:0] key_payload;

    logic [NUM_TYPES-1:0]    hits;
    logic [NUM_TYPES:0]      shift;
    logic [TYPE_W-1:0]       cell_type [NUM_TYPES+1];
    logic [PAYLOAD_BITS-1:0] cell_pay  [NUM_TYPES+1];
    ctq_cell_cmd_t           cmd       [NUM_TYPES];

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_enq    = (req.data.op == OP_ENQ);
    assign empty     = (cnt_reg == '0);
    assign full      = (cnt_reg == CNT_W'(NUM_TYPES));
    assign any_hit   = |hits;

    // head leaves on a dequeue, or on an enqueue of a new type into a full queue
    assign drop_head = is_enq ? (!any_hit && full) : !empty;
    assign removed   = drop_head || (is_enq && any_hit);
    assign cnt_after = cnt_reg - CNT_W'(removed);
    assign cnt_next  = cnt_after + CNT_W'(is_enq);

    assign in_pay64    = {32'b0, req.data.payload};
    assign key_payload = in_pay64[PAYLOAD_BITS-1:0];

    assign shift[0]             = drop_head;
    assign cell_type[NUM_TYPES] = '0;
    assign cell_pay[NUM_TYPES]  = '0;

    for (genvar k = 0; k < NUM_TYPES; k++)
    begin : g_cell
        assign cmd[k].en       = accept;
        assign cmd[k].enq      = is_enq;
        assign cmd[k].occupied = (CNT_W'(k) < cnt_reg);
        assign cmd[k].load_new = is_enq && (cnt_after == CNT_W'(k));

        ctq_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd[k]),
            .key_type    (req.data.msg_type),
            .key_payload (key_payload),
            .shift_in    (shift[k]),
            .nb_type     (cell_type[k+1]),
            .nb_payload  (cell_pay[k+1]),
            .hit         (hits[k]),
            .shift_out   (shift[k+1]),
            .cur_type    (cell_type[k]),
            .cur_payload (cell_pay[k])
        );
    end

    assign head_pay64 = 64'(cell_pay[0]);

    always_comb
    begin
        rsp_next             = '0;
        rsp_next.occupancy   = OCC_W'(cnt_next);
        if (is_enq)
        begin
            rsp_next.status = any_hit ? ST_REPLACE : ST_ENQ;
        end
        else if (empty)
        begin
            rsp_next.status = ST_EMPTY;
        end
        else
        begin
            rsp_next.status      = ST_DEQ;
            rsp_next.out_type    = cell_type[0];
            rsp_next.out_payload = head_pay64[PAYLOAD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg       <= cnt_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    `CTQ_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(NUM_TYPES))
    `CTQ_ASSERT_IMP(a_single_hit, clk, rst_n, 1'b1, $onehot0(hits))
    `CTQ_ASSERT_NXT(a_rsp_follows, clk, rst_n, accept, rsp_valid_reg)
    `CTQ_ASSERT_NXT(a_enq_nonempty, clk, rst_n, accept && is_enq, cnt_reg != '0)
    `CTQ_ASSERT_NXT(a_deq_empty_keeps, clk, rst_n, accept && !is_enq && empty,
                    cnt_reg == '0)

endmodule

// ----- src/ctq_cell.sv -----
// One queue slot: holds a type and payload, matches the incoming type and
// shifts toward the head when an entry at or before it is removed. Uses ctq_pkg.
module ctq_cell #(
    parameter int PAYLOAD_BITS = ctq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                          clk,
    input  ctq_pkg::ctq_cell_cmd_t        cmd,
    input  logic [ctq_pkg::TYPE_W-1:0]    key_type,
    input  logic [PAYLOAD_BITS-1:0]       key_payload,
    input  logic                          shift_in,
    input  logic [ctq_pkg::TYPE_W-1:0]    nb_type,
    input  logic [PAYLOAD_BITS-1:0]       nb_payload,
    output logic                          hit,
    output logic                          shift_out,
    output logic [ctq_pkg::TYPE_W-1:0]    cur_type,
    output logic [PAYLOAD_BITS-1:0]       cur_payload
);
    import ctq_pkg::*;

    logic [TYPE_W-1:0]       type_reg;
    logic [PAYLOAD_BITS-1:0] payload_reg;

    assign hit       = cmd.enq && cmd.occupied && (type_reg == key_type);
    // removal point at this cell or earlier in the chain
    assign shift_out = shift_in | hit;

    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            if (cmd.load_new)
            begin
                type_reg    <= key_type;
                payload_reg <= key_payload;
            end
            else if (shift_out)
            begin
                type_reg    <= nb_type;
                payload_reg <= nb_payload;
            end
        end
    end

    assign cur_type    = type_reg;
    assign cur_payload = payload_reg;

endmodule
